FILE: src/pbpa_pkg.sv
// Package for the power-of-two block pool allocator.
// Holds the widths, mode and status codes, the shared structs and the size rounding function.
// No dependencies.
package pbpa_pkg;

    // table geometry
    localparam int SLOT_COUNT    = 32;
    localparam int IDX_W         = $clog2(SLOT_COUNT);
    localparam int MAX_SIZE_LOG2 = 36;

    // field widths
    localparam int MODE_W   = 2;
    localparam int CNT_W    = 37;
    localparam int HANDLE_W = 5;
    localparam int LOG_W    = 6;
    localparam int ACC_W    = 42;
    localparam int STAT_W   = 2;

    // port packing
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_FIELD_W = HANDLE_W + 1 + 1 + CNT_W + ACC_W + ACC_W + STAT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // bypass threshold after reset
    localparam logic [CNT_W-1:0] BYPASS_RESET = CNT_W'(104857);

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAN = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERSIZE = 2'd2;

    // one slot entry in the table memory
    typedef struct packed {
        logic             busy;
        logic [LOG_W-1:0] size_log2;
    } slot_entry_t;

    // memory access from the controller
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        slot_entry_t       wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } mem_req_t;

    // one result item
    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [ACC_W-1:0]    pool_total;
        logic [ACC_W-1:0]    released_bytes;
        logic [CNT_W-1:0]    rounded_bytes;
        logic                fresh_block;
        logic                bypassed;
        logic [HANDLE_W-1:0] granted_slot;
    } result_t;

    // smallest k with 2^k >= n, n >= 1; leading-one search on n - 1
    function automatic logic [LOG_W-1:0] ceil_log2(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] m;
        logic [LOG_W-1:0] k;
        m = n - CNT_W'(1);
        k = '0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (m[i])
            begin
                k = LOG_W'(i + 1);
            end
        end
        if (n <= CNT_W'(1))
        begin
            k = '0;
        end
        return k;
    endfunction

endpackage

FILE: src/pbpa_slot_ram.sv
// Slot table memory: busy bit and size class of each slot.
// One write port, one read port with registered read data. Uses pbpa_pkg.
module pbpa_slot_ram (
    input  logic                clk,
    input  pbpa_pkg::mem_req_t  req,
    output pbpa_pkg::slot_entry_t rd_data
);
    import pbpa_pkg::*;

    slot_entry_t mem [SLOT_COUNT];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

FILE: src/pbpa_ctrl.sv
// Allocator control: sequencer that scans the slot table memory and keeps valid bits and total.
// Drives pbpa_slot_ram through a mem_req_t. Uses pbpa_pkg.
module pbpa_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pbpa_pkg::MODE_W-1:0]   mode,
    input  logic [pbpa_pkg::CNT_W-1:0]    byte_count,
    input  logic [pbpa_pkg::HANDLE_W-1:0] slot_handle,
    input  logic [pbpa_pkg::CNT_W-1:0]    threshold,
    output logic                          idle,
    output pbpa_pkg::mem_req_t            mem_req,
    input  pbpa_pkg::slot_entry_t         mem_rd_data,
    output logic                          res_valid,
    input  logic                          res_take,
    output pbpa_pkg::result_t             res
);
    import pbpa_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_PREP    = 6'b000010,
        ST_SCAN    = 6'b000100,
        ST_COMMIT  = 6'b001000,
        ST_FREE_WB = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [SLOT_COUNT-1:0] valid_reg, valid_next;
    logic [ACC_W-1:0]      held_reg, held_next;

    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [LOG_W-1:0]    k_reg, k_next;
    logic [IDX_W:0]      scan_addr_reg, scan_addr_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic                empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]    empty_idx_reg, empty_idx_next;
    logic [ACC_W-1:0]    released_reg, released_next;
    logic [HANDLE_W-1:0] granted_reg, granted_next;
    logic                bypassed_reg, bypassed_next;
    logic                fresh_reg, fresh_next;
    logic [CNT_W-1:0]    rounded_reg, rounded_next;
    logic [STAT_W-1:0]   status_reg, status_next;

    logic [LOG_W-1:0] k_calc;
    logic             small_req;
    logic             handle_ok;
    logic             chk_slot_valid;
    logic [ACC_W-1:0] chk_size;

    assign k_calc         = ceil_log2(count_reg);
    assign small_req      = (count_reg <= threshold);
    assign handle_ok      = ({1'b0, handle_reg} < (HANDLE_W + 1)'(SLOT_COUNT));
    assign chk_slot_valid = valid_reg[chk_idx_reg];
    assign chk_size       = ACC_W'(1) << mem_rd_data.size_log2;

    // sequencer; each item reads and writes back its own entries only, and the
    // write of one item lands before the next item reads, with ST_DONE and ST_IDLE between
    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        held_next        = held_reg;
        mode_next        = mode_reg;
        count_next       = count_reg;
        handle_next      = handle_reg;
        k_next           = k_reg;
        scan_addr_next   = scan_addr_reg;
        chk_vld_next     = 1'b0;
        chk_idx_next     = chk_idx_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        released_next    = released_reg;
        granted_next     = granted_reg;
        bypassed_next    = bypassed_reg;
        fresh_next       = fresh_reg;
        rounded_next     = rounded_reg;
        status_next      = status_reg;
        mem_req          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next   = mode;
                    count_next  = byte_count;
                    handle_next = slot_handle;
                    state_next  = ST_PREP;
                end
            end

            // size class, bypass, oversize and free handle decisions
            ST_PREP:
            begin
                k_next           = k_calc;
                scan_addr_next   = '0;
                hit_found_next   = 1'b0;
                empty_found_next = 1'b0;
                released_next    = '0;
                granted_next     = '0;
                bypassed_next    = 1'b0;
                fresh_next       = 1'b0;
                rounded_next     = '0;
                status_next      = STAT_OK;
                state_next       = ST_DONE;
                unique case (mode_reg)
                    MODE_ALLOC:
                    begin
                        if (small_req)
                        begin
                            bypassed_next = 1'b1;
                        end
                        else if (k_calc > LOG_W'(MAX_SIZE_LOG2))
                        begin
                            status_next = STAT_OVERSIZE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    MODE_FREE:
                    begin
                        if (small_req)
                        begin
                            bypassed_next = 1'b1;
                        end
                        else if (handle_ok && valid_reg[handle_reg[IDX_W-1:0]])
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = handle_reg[IDX_W-1:0];
                            state_next      = ST_FREE_WB;
                        end
                    end
                    MODE_CLEAN:
                    begin
                        state_next = ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            // one read issued and one entry checked per cycle
            ST_SCAN:
            begin
                if (scan_addr_reg < (IDX_W + 1)'(SLOT_COUNT))
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_addr_reg[IDX_W-1:0];
                    scan_addr_next  = scan_addr_reg + 1'b1;
                    chk_vld_next    = 1'b1;
                    chk_idx_next    = scan_addr_reg[IDX_W-1:0];
                end
                if (chk_vld_reg)
                begin
                    if (mode_reg == MODE_ALLOC)
                    begin
                        if (chk_slot_valid && !mem_rd_data.busy &&
                            (mem_rd_data.size_log2 == k_reg) && !hit_found_reg)
                        begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = chk_idx_reg;
                        end
                        if (!chk_slot_valid && !empty_found_reg)
                        begin
                            empty_found_next = 1'b1;
                            empty_idx_next   = chk_idx_reg;
                        end
                    end
                    else if (chk_slot_valid && !mem_rd_data.busy &&
                             (chk_size > ACC_W'(count_reg)))
                    begin
                        valid_next[chk_idx_reg] = 1'b0;
                        released_next = released_reg + chk_size;
                        held_next     = held_reg - chk_size;
                    end
                    if (chk_idx_reg == IDX_W'(SLOT_COUNT - 1))
                    begin
                        state_next = (mode_reg == MODE_ALLOC) ? ST_COMMIT : ST_DONE;
                    end
                end
            end

            // reuse an idle slot, else claim an empty one, else report full
            ST_COMMIT:
            begin
                mem_req.wr_data.busy      = 1'b1;
                mem_req.wr_data.size_log2 = k_reg;
                state_next                = ST_DONE;
                if (hit_found_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = hit_idx_reg;
                    granted_next    = HANDLE_W'(hit_idx_reg);
                    rounded_next    = CNT_W'(1) << k_reg;
                end
                else if (empty_found_reg)
                begin
                    mem_req.wr_en             = 1'b1;
                    mem_req.wr_addr           = empty_idx_reg;
                    valid_next[empty_idx_reg] = 1'b1;
                    held_next    = held_reg + (ACC_W'(1) << k_reg);
                    granted_next = HANDLE_W'(empty_idx_reg);
                    rounded_next = CNT_W'(1) << k_reg;
                    fresh_next   = 1'b1;
                end
                else
                begin
                    status_next = STAT_FULL;
                end
            end

            // write back the freed entry with its size kept
            ST_FREE_WB:
            begin
                mem_req.wr_en             = 1'b1;
                mem_req.wr_addr           = handle_reg[IDX_W-1:0];
                mem_req.wr_data.busy      = 1'b0;
                mem_req.wr_data.size_log2 = mem_rd_data.size_log2;
                state_next                = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            held_reg    <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            held_reg    <= held_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    // item payload and scan bookkeeping
    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        count_reg       <= count_next;
        handle_reg      <= handle_next;
        k_reg           <= k_next;
        scan_addr_reg   <= scan_addr_next;
        chk_idx_reg     <= chk_idx_next;
        hit_found_reg   <= hit_found_next;
        hit_idx_reg     <= hit_idx_next;
        empty_found_reg <= empty_found_next;
        empty_idx_reg   <= empty_idx_next;
        released_reg    <= released_next;
        granted_reg     <= granted_next;
        bypassed_reg    <= bypassed_next;
        fresh_reg       <= fresh_next;
        rounded_reg     <= rounded_next;
        status_reg      <= status_next;
    end

    // result of the finished item
    assign idle               = (state_reg == ST_IDLE);
    assign res_valid          = (state_reg == ST_DONE);
    assign res.granted_slot   = granted_reg;
    assign res.bypassed       = bypassed_reg;
    assign res.fresh_block    = fresh_reg;
    assign res.rounded_bytes  = rounded_reg;
    assign res.released_bytes = released_reg;
    assign res.pool_total     = held_reg;
    assign res.status         = status_reg;

endmodule

FILE: src/pow2_block_pool_allocator.sv
// Power-of-two block pool allocator, top level.
// A pooled allocate and a clean read each slot once from the slot table memory; a free of a
// valid slot reads its entry and writes it back; other items touch no memory.
// One item at a time; the next item is accepted the cycle after the result is registered.
// Reset clears valid bits, pool total and handshake state; threshold returns to 104857.
module pow2_block_pool_allocator (
    input  logic                               clk,
    input  logic                               rst_n,
    // slave side
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pbpa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // byte_count, slot_handle
    input  logic [pbpa_pkg::MODE_W-1:0]        s_axis_tuser,  // mode
    // master side
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // granted_slot, bypassed, fresh_block, rounded_bytes, released_bytes, pool_total, status
    output logic [pbpa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // bypass threshold register
    input  logic                               cfg_we,
    input  logic [pbpa_pkg::CNT_W-1:0]         cfg_wdata
);
    import pbpa_pkg::*;

    logic [CNT_W-1:0] thr_reg;
    logic             out_valid_reg;
    result_t          out_res_reg;

    logic        ctrl_idle;
    logic        s_accept;
    logic        res_valid;
    logic        res_take;
    logic        res_load;
    result_t     res;
    mem_req_t    mem_req;
    slot_entry_t mem_rd_data;

    assign s_axis_tready = ctrl_idle;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign res_take      = !out_valid_reg || m_axis_tready;
    assign res_load      = res_valid && res_take;

    // bypass threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= BYPASS_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    pbpa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (s_accept),
        .mode        (s_axis_tuser),
        .byte_count  (s_axis_tdata[CNT_W-1:0]),
        .slot_handle (s_axis_tdata[CNT_W+HANDLE_W-1:CNT_W]),
        .threshold   (thr_reg),
        .idle        (ctrl_idle),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res)
    );

    pbpa_slot_ram u_slot_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_res_reg};

    // engine takes one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_axis_tready)
        else $error("item accepted while engine busy");

    // a claimed slot is always a successful pooled grant
    a_fresh_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.fresh_block) |->
        (out_res_reg.status == STAT_OK && !out_res_reg.bypassed &&
         out_res_reg.rounded_bytes != '0))
        else $error("fresh block with bad status");

    // bypassed items touch nothing in the pool
    a_bypass_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.bypassed) |->
        (out_res_reg.rounded_bytes == '0 && out_res_reg.released_bytes == '0 &&
         out_res_reg.status == STAT_OK))
        else $error("bypassed item with pool result");

endmodule

FILE: test/pow2_block_pool_allocator_test.sv
`timescale 1ns / 1ps
// Testbench for the power-of-two block pool allocator: queue-fed stream driver, result monitor,
// and a per-item predictor of the slot table, pool total and bypass threshold.
// Depends on pbpa_pkg and pow2_block_pool_allocator.
module pow2_block_pool_allocator_test;
    import pbpa_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam longint unsigned MAX_BYTES = 64'd1 << MAX_SIZE_LOG2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT = 120;
    localparam int HOLD_LEN = 300;
    localparam int SETTLE_CYCLES = 40;

    // one request as it travels on the slave side
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [HANDLE_W-1:0] handle;
        logic [CNT_W-1:0]    count;
    } pool_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;  // byte_count, slot_handle
    logic [MODE_W-1:0] s_axis_tuser = MODE_ALLOC;  // mode
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // granted_slot, bypassed, fresh_block, rounded_bytes, released_bytes, pool_total, status
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;

    // requests waiting to be offered, results waiting to arrive
    pool_req_t pool_requests[$];
    result_t expected_outcomes[$];

    // predicted block state
    bit slot_live[SLOT_COUNT];
    bit slot_taken[SLOT_COUNT];
    logic [LOG_W-1:0] slot_log[SLOT_COUNT];
    logic [ACC_W-1:0] pool_bytes = '0;
    logic [CNT_W-1:0] bypass_model = BYPASS_RESET;

    bit idle_on = 1'b1;
    bit long_hold;
    int hold_cycles;
    int send_gap;
    int take_gap;
    int accepted_items;
    int results_seen = 0;
    int errors = 0;
    int cycles = 0;
    int n_fresh = 0, n_reuse = 0, n_bypass = 0, n_full = 0, n_oversize = 0, n_release = 0;
    pool_req_t next_req;
    result_t seen, want;

    pow2_block_pool_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    // smallest k with 2^k >= n
    function automatic int size_class(input longint unsigned n);
        int k;
        k = 0;
        while (k < 63 && (64'd1 << k) < n)
        begin
            k++;
        end
        return k;
    endfunction

    function automatic longint unsigned rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic pool_req_t mk_req(input logic [MODE_W-1:0] mode,
                                         input longint unsigned count,
                                         input int handle);
        pool_req_t rq;
        rq.mode = mode;
        rq.count = CNT_W'(count);
        rq.handle = HANDLE_W'(handle);
        return rq;
    endfunction

    // work out one result and advance the predicted table
    function automatic result_t pool_predict(input logic [MODE_W-1:0] mode,
                                             input logic [CNT_W-1:0] cnt,
                                             input logic [HANDLE_W-1:0] hnd);
        result_t r;
        int k, hit, empty;
        logic [ACC_W-1:0] sz;
        r = '0;
        hit = -1;
        empty = -1;
        k = size_class(cnt);
        case (mode)
            MODE_ALLOC:
            begin
                if (cnt <= bypass_model)
                begin
                    r.bypassed = 1'b1;
                    n_bypass++;
                end
                else if (k > MAX_SIZE_LOG2)
                begin
                    r.status = STAT_OVERSIZE;
                    n_oversize++;
                end
                else
                begin
                    // lowest idle slot of equal size, else lowest unused slot
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (slot_live[i])
                        begin
                            if (hit < 0 && !slot_taken[i] && slot_log[i] == LOG_W'(k))
                            begin
                                hit = i;
                            end
                        end
                        else if (empty < 0)
                        begin
                            empty = i;
                        end
                    end
                    if (hit >= 0)
                    begin
                        slot_taken[hit] = 1'b1;
                        r.granted_slot = HANDLE_W'(hit);
                        r.rounded_bytes = CNT_W'(64'd1 << k);
                        n_reuse++;
                    end
                    else if (empty >= 0)
                    begin
                        slot_live[empty] = 1'b1;
                        slot_taken[empty] = 1'b1;
                        slot_log[empty] = LOG_W'(k);
                        pool_bytes = pool_bytes + ACC_W'(64'd1 << k);
                        r.granted_slot = HANDLE_W'(empty);
                        r.rounded_bytes = CNT_W'(64'd1 << k);
                        r.fresh_block = 1'b1;
                        n_fresh++;
                    end
                    else
                    begin
                        r.status = STAT_FULL;
                        n_full++;
                    end
                end
            end
            MODE_FREE:
            begin
                if (cnt <= bypass_model)
                begin
                    r.bypassed = 1'b1;
                    n_bypass++;
                end
                else if (slot_live[hnd])
                begin
                    slot_taken[hnd] = 1'b0;
                end
            end
            MODE_CLEAN:
            begin
                // drop idle slots above the size threshold
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (slot_live[i] && !slot_taken[i])
                    begin
                        sz = ACC_W'(64'd1 << slot_log[i]);
                        if (sz > ACC_W'(cnt))
                        begin
                            slot_live[i] = 1'b0;
                            r.released_bytes = r.released_bytes + sz;
                        end
                    end
                end
                pool_bytes = pool_bytes - r.released_bytes;
                if (r.released_bytes != '0)
                begin
                    n_release++;
                end
            end
            default:
            begin
            end
        endcase
        r.pool_total = pool_bytes;
        return r;
    endfunction

    // size above the threshold, mostly from a few classes so that slots get reused
    function automatic longint unsigned pooled_count(input longint unsigned thr);
        int klo, k;
        longint unsigned c;
        klo = size_class(thr + 1);
        if (klo > MAX_SIZE_LOG2)
        begin
            return thr + 1;
        end
        if ($urandom_range(0, 9) < 7)
        begin
            k = klo + $urandom_range(0, 3);
        end
        else
        begin
            k = $urandom_range(klo, MAX_SIZE_LOG2);
        end
        if (k > MAX_SIZE_LOG2)
        begin
            k = MAX_SIZE_LOG2;
        end
        if (k == 0)
        begin
            c = 1;
        end
        else
        begin
            c = (64'd1 << (k - 1)) + 1 + rand64() % (64'd1 << (k - 1));
        end
        if (c <= thr)
        begin
            c = thr + 1;
        end
        return c;
    endfunction

    function automatic pool_req_t random_req(input longint unsigned thr);
        pool_req_t rq;
        int pick, sub, hnd;
        longint unsigned c;
        pick = $urandom_range(0, 99);
        sub = $urandom_range(0, 99);
        // frees mostly aim at the low slots, which fill first
        hnd = ($urandom_range(0, 9) < 5) ? $urandom_range(0, 7) : $urandom_range(0, 31);
        if (pick < 55)
        begin
            if (sub < 80)
                c = pooled_count(thr);
            else if (sub < 88)
                c = rand64() % (thr + 1);
            else if (sub < 96)
                c = rand64() % (MAX_BYTES + 1);
            else
                c = MAX_BYTES + 1 + rand64() % (MAX_BYTES - 1);
            rq = mk_req(MODE_ALLOC, c, hnd);
        end
        else if (pick < 85)
        begin
            c = (sub < 85) ? pooled_count(thr) : rand64() % (thr + 1);
            rq = mk_req(MODE_FREE, c, hnd);
        end
        else if (pick < 97)
        begin
            if (sub < 60)
                c = (64'd1 << $urandom_range(0, MAX_SIZE_LOG2)) - $urandom_range(0, 1);
            else
                c = rand64() % (MAX_BYTES + 1);
            rq = mk_req(MODE_CLEAN, c, hnd);
        end
        else
        begin
            rq = mk_req(MODE_UNUSED, rand64() % (MAX_BYTES + 1), hnd);
        end
        return rq;
    endfunction

    // append a request to the pending list
    function automatic void add_req(input pool_req_t rq);
        pool_requests.insert(pool_requests.size(), rq);
    endfunction

    function automatic void compare_field(input string name, input longint unsigned exp_v,
                                          input longint unsigned act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_outcomes.size());
            $display("status: fail");
            $finish;
        end
    end

    // driver: predict on accept, then offer the next item or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= MODE_ALLOC;
            send_gap = 0;
            accepted_items <= 0;
        end
        else
        begin
            // threshold copy follows register writes
            if (cfg_we)
            begin
                bypass_model = cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_outcomes.insert(expected_outcomes.size(),
                                         pool_predict(s_axis_tuser, s_axis_tdata[CNT_W-1:0],
                                                      s_axis_tdata[CNT_W +: HANDLE_W]));
                accepted_items <= accepted_items + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(0, 3);
                    s_axis_tvalid <= 1'b0;
                end
                else if (pool_requests.size() != 0)
                begin
                    next_req = pool_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= next_req.mode;
                    s_axis_tdata <= IN_TDATA_W'({next_req.handle, next_req.count});
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold <= 1'b0;
            hold_cycles <= 0;
        end
        else if (long_hold)
        begin
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == HOLD_LEN - 1)
            begin
                long_hold <= 1'b0;
            end
        end
        else if (hold_cycles == 0 && accepted_items >= HOLD_AT)
        begin
            long_hold <= 1'b1;
        end
    end

    // monitor: check each result against the oldest prediction, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            take_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = result_t'(m_axis_tdata[OUT_FIELD_W-1:0]);
                results_seen++;
                if (expected_outcomes.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %0h", $time, seen);
                    errors++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    compare_field("granted_slot", want.granted_slot, seen.granted_slot);
                    compare_field("bypassed", want.bypassed, seen.bypassed);
                    compare_field("fresh_block", want.fresh_block, seen.fresh_block);
                    compare_field("rounded_bytes", want.rounded_bytes, seen.rounded_bytes);
                    compare_field("released_bytes", want.released_bytes, seen.released_bytes);
                    compare_field("pool_total", want.pool_total, seen.pool_total);
                    compare_field("status", want.status, seen.status);
                end
            end
            if (long_hold)
            begin
                m_axis_tready <= 1'b0;
            end
            else if (take_gap > 0)
            begin
                take_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                take_gap = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // wait until every item is out, then let the block settle
    task automatic drain();
        @(negedge clk);
        while (pool_requests.size() != 0 || s_axis_tvalid || expected_outcomes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [CNT_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] thr, input int n, input bit noisy);
        write_threshold(thr);
        idle_on = noisy;
        for (int i = 0; i < n; i++)
        begin
            add_req(random_req(thr));
        end
        drain();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: threshold from reset, size extremes, reuse, frees, cleans, unused mode
        add_req(mk_req(MODE_ALLOC, 0, 0));
        add_req(mk_req(MODE_ALLOC, 104857, 0));
        add_req(mk_req(MODE_ALLOC, 104858, 0));
        add_req(mk_req(MODE_ALLOC, 131072, 0));
        add_req(mk_req(MODE_FREE, 131072, 0));
        add_req(mk_req(MODE_ALLOC, 120000, 31));
        add_req(mk_req(MODE_ALLOC, MAX_BYTES, 0));
        add_req(mk_req(MODE_ALLOC, MAX_BYTES + 1, 0));
        add_req(mk_req(MODE_ALLOC, (64'd1 << CNT_W) - 1, 0));
        add_req(mk_req(MODE_FREE, 0, 31));
        add_req(mk_req(MODE_FREE, 104857, 2));
        add_req(mk_req(MODE_FREE, 64'd1 << 20, 31));
        add_req(mk_req(MODE_FREE, MAX_BYTES, 2));
        add_req(mk_req(MODE_FREE, 104858, 1));
        add_req(mk_req(MODE_CLEAN, MAX_BYTES, 0));
        add_req(mk_req(MODE_CLEAN, 131072, 0));
        add_req(mk_req(MODE_UNUSED, MAX_BYTES - 1, 21));
        add_req(mk_req(MODE_ALLOC, 3000000, 0));
        add_req(mk_req(MODE_ALLOC, 3000000, 0));
        add_req(mk_req(MODE_FREE, 3000000, 1));
        add_req(mk_req(MODE_CLEAN, 0, 0));
        add_req(mk_req(MODE_UNUSED, 0, 0));
        drain();

        // random phases across threshold settings, extremes included
        run_phase('0, 250, 1'b1);
        run_phase(CNT_W'(MAX_BYTES), 30, 1'b1);
        run_phase(CNT_W'(64'd1 << 20), 300, 1'b1);
        run_phase(CNT_W'($urandom_range(0, 1 << 24)), 170, 1'b1);
        run_phase(BYPASS_RESET, 100, 1'b0);

        if (expected_outcomes.size() != 0)
        begin
            $display("%0d results never arrived", expected_outcomes.size());
            errors++;
        end
        $display("%0d results checked: %0d fresh slots, %0d reuses, %0d bypassed, %0d full",
                 results_seen, n_fresh, n_reuse, n_bypass, n_full);
        $display("%0d oversize, %0d cleans that released bytes, %0d mismatches",
                 n_oversize, n_release, errors);
        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
src/pbpa_pkg.sv
src/pbpa_slot_ram.sv
src/pbpa_ctrl.sv
src/pow2_block_pool_allocator.sv
test/pow2_block_pool_allocator_test.sv
